// ===== rtl/core/stq_pkg.sv =====
// Package for the sorted timer queue: item types, opcodes, result kinds and sizes.
// No dependencies; used by every module of the block.
package stq_pkg;

   localparam int TIMERS = 16;
   localparam int TIME_BITS = 48;
   localparam int ID_BITS = 4;
   localparam int CNT_BITS = 5;
   localparam int EXP_BITS = TIME_BITS + 1;
   localparam int MAX_OUT = 16;
   localparam int US_PER_MS = 1000;
   localparam logic [48:0] IDLE_DELAY_US = 49'd1000000000;

   typedef enum logic [1:0] {
      OP_SCHEDULE   = 2'd0,
      OP_UNSCHEDULE = 2'd1,
      OP_RUN        = 2'd2,
      OP_QUERY      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_FIRED   = 2'd1,
      KIND_NONE    = 2'd2,
      KIND_DELAY   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  timer_id;
      logic [30:0] delay_ms;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  fired_id;
      logic [48:0] delay_us;
      logic        has_timer;
      logic        last;
   } rsp_type;

   // Command handed from the front to the back: the expiry is already computed.
   typedef struct packed {
      opcode_type          op;
      logic [ID_BITS-1:0]  id;
      logic                id_ok;
      logic [EXP_BITS-1:0] when;
      logic [EXP_BITS-1:0] now;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SHIFT,
      ST_INS,
      ST_RUN,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/core/sorted_timer_queue_core.sv =====
// Sorted timer queue: up to 16 timers ordered by expiry. One item at a time in the back
// end; a schedule walks the list one entry per cycle, and a run delivers one fired
// timer per cycle while the result output is not stalled.
// The front computes the expiry in two stages and buffers one command.
// Depends on stq_pkg, stq_front and stq_back.
module sorted_timer_queue_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   stq_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   stq_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== rtl/core/stq_front.sv =====
// Front of the timer queue: accepts items and computes the expiry time.
// Depends on stq_pkg. Two-stage: multiply by 1000 is registered before the add.
module stq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output stq_pkg::cmd_type cmd_data
);
   import stq_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_ff;
   logic [40:0] prod_ff;
   logic       s2_valid_ff, s2_valid_in;
   cmd_type    s2_ff, s2_in;
   logic       adv2, adv1;

   assign adv2 = !s2_valid_ff || cmd_take;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (adv1) s1_valid_in = req_valid;
      s2_valid_in = s2_valid_ff;
      if (adv2) s2_valid_in = s1_valid_ff;
      s2_in.op    = opcode_type'(s1_ff.opcode);
      s2_in.id    = s1_ff.timer_id;
      s2_in.id_ok = ({1'b0, s1_ff.timer_id} < 5'(TIMERS));
      s2_in.now   = {1'b0, s1_ff.now_us[TIME_BITS-1:0]};
      s2_in.when  = EXP_BITS'({1'b0, s1_ff.now_us[TIME_BITS-1:0]} + 50'(prod_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (adv1) begin
         s1_ff   <= req_data;
      end
      if (adv1) begin
         prod_ff <= 41'(req_data.delay_ms) * 41'(US_PER_MS);
      end
      if (adv2) s2_ff <= s2_in;
   end

   // The product stage travels with stage one; it is registered at the same edge.
   assign cmd_valid = s2_valid_ff;
   assign cmd_data  = s2_ff;
endmodule

// ===== rtl/core/stq_back.sv =====
// Back of the timer queue: keeps the sorted list and carries out each command.
// Depends on stq_pkg. One list entry is visited per cycle.
module stq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  stq_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [EXP_BITS-1:0] expiry_ff [TIMERS];
   logic [ID_BITS-1:0]  order_ff [TIMERS];
   logic [TIMERS-1:0]   armed_ff, armed_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0] nout_ff, nout_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;
   logic                out_free;
   logic [ID_BITS-1:0]  head_id;
   logic [EXP_BITS-1:0] head_exp;
   logic [ID_BITS-1:0]  next_id;
   logic [EXP_BITS-1:0] next_exp;
   logic                more_due;
   logic [ID_BITS-1:0]  pos_id;
   // list write controls
   logic                sh_left, sh_right, ins_we, exp_we;
   logic [CNT_BITS-1:0] sh_from;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign head_id  = order_ff[0];
   assign head_exp = expiry_ff[head_id];
   assign pos_id   = order_ff[pos_ff[ID_BITS-1:0]];
   // The entry behind the head decides whether the timer popped now is the last one.
   assign next_id  = order_ff[1];
   assign next_exp = expiry_ff[next_id];
   assign more_due = count_ff > CNT_BITS'(1) && next_exp <= cmd_ff.now
                     && nout_ff < CNT_BITS'(MAX_OUT - 1);

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; armed_in = armed_ff;
      count_in = count_ff; pos_in = pos_ff; nout_in = nout_ff;
      out_valid_in = out_valid_ff && rsp_stall; out_in = out_ff;
      cmd_take = 1'b0; sh_left = 1'b0; sh_right = 1'b0; ins_we = 1'b0;
      exp_we = 1'b0; sh_from = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in = cmd_data;
               pos_in = '0;
               nout_in = '0;
               unique case (cmd_data.op) inside
                  OP_SCHEDULE, OP_UNSCHEDULE: begin
                     if (cmd_data.id_ok && armed_ff[cmd_data.id]) state_in = ST_FIND;
                     else if (cmd_data.id_ok && cmd_data.op == OP_SCHEDULE)
                        state_in = ST_INS;
                     else state_in = ST_OUT;
                  end
                  OP_RUN:   state_in = ST_RUN;
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_FIND: begin
            // Walk to the slot, then close the gap it leaves.
            if (pos_id == cmd_ff.id) begin
               sh_left = 1'b1;
               armed_in[cmd_ff.id] = 1'b0;
               count_in = count_ff - 1'b1;
               pos_in = '0;
               state_in = (cmd_ff.op == OP_SCHEDULE) ? ST_INS : ST_OUT;
            end else pos_in = pos_ff + 1'b1;
         end
         ST_INS: begin
            if (pos_ff < count_ff && cmd_ff.when > expiry_ff[pos_id])
               pos_in = pos_ff + 1'b1;
            else begin
               exp_we = 1'b1; sh_right = 1'b1; ins_we = 1'b1;
               armed_in[cmd_ff.id] = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               if (count_ff != '0 && head_exp <= cmd_ff.now
                   && nout_ff < CNT_BITS'(MAX_OUT)) begin
                  sh_left = 1'b1; sh_from = '0;
                  armed_in[head_id] = 1'b0;
                  count_in = count_ff - 1'b1;
                  nout_in = nout_ff + 1'b1;
                  out_valid_in = 1'b1;
                  out_in = '{kind: KIND_FIRED, fired_id: head_id, delay_us: '0,
                             has_timer: 1'b0, last: !more_due};
                  if (!more_due) state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = '{kind: KIND_ACK, fired_id: '0, delay_us: '0,
                          has_timer: 1'b0, last: 1'b1};
               if (cmd_ff.op == OP_RUN) out_in.kind = KIND_NONE;
               else if (cmd_ff.op == OP_QUERY) begin
                  out_in.kind = KIND_DELAY;
                  if (count_ff == '0) out_in.delay_us = IDLE_DELAY_US;
                  else begin
                     out_in.has_timer = 1'b1;
                     out_in.delay_us = (head_exp > cmd_ff.now) ? head_exp - cmd_ff.now : '0;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid = out_valid_ff;
      rsp_data  = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         armed_ff <= '0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff <= cmd_in;
      pos_ff <= pos_in;
      nout_ff <= nout_in;
      out_ff <= out_in;
      if (exp_we) expiry_ff[cmd_ff.id] <= cmd_ff.when;
      for (int i = 0; i < TIMERS; i++) begin
         if (sh_left && CNT_BITS'(i) >= sh_from && i < TIMERS - 1)
            order_ff[i] <= order_ff[(i + 1) % TIMERS];
         if (sh_right && CNT_BITS'(i) > pos_ff && i > 0)
            order_ff[i] <= order_ff[(i + TIMERS - 1) % TIMERS];
      end
      if (ins_we) order_ff[pos_ff[ID_BITS-1:0]] <= cmd_ff.id;
   end
endmodule

// ===== rtl/core/stq_checker.sv =====
// Port checker for the sorted timer queue; bound to the top level.
// Depends on stq_pkg.
module stq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input stq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_ACK || rsp_data.kind == KIND_DELAY
                    || rsp_data.kind == KIND_NONE) |-> rsp_data.last)
      else $error("single result without last");

   a_no_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_DELAY && !rsp_data.has_timer
      |-> rsp_data.delay_us == IDLE_DELAY_US)
      else $error("idle delay wrong");
endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (.*);
